/* design/dpalu_pkg.sv */
package dpalu_pkg;

    typedef enum logic [3:0] {
        OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
        OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
        OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
        OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
    } alu_op_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
    } shift_kind_t;

    localparam logic [31:0] CLZ_MASK    = 32'h0FFF0FF0;
    localparam logic [31:0] CLZ_PATTERN = 32'h016F0F10;

    // classified item passed from front to back
    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] rn;
        logic [31:0] rm;
        logic [7:0]  amt;
    } dec_item_t;

endpackage

/* design/data_processing_alu_with_flags.sv */
// channel | signals                                            | direction
// input   | in_valid/in_ready, instr_word, first_operand,      | into block
//         | shift_source, shift_amount_reg                     |
// output  | out_valid/out_ready, result_value, result_write,   | out of block
//         | dest_index, nzcv_out, cond_passed, handled         |
//
// one item per cycle sustained while out_ready is high; each item passes the queue stage, then execute
// the execute stage reads and updates the flag register in one cycle
// front holds up to two items in a small queue so either side may stall alone
// rst_n clears the queue, the output valid and the flags (all zero)
module data_processing_alu_with_flags
    import dpalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr_word,
    input  logic [31:0] first_operand,
    input  logic [31:0] shift_source,
    input  logic [31:0] shift_amount_reg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic        result_write,
    output logic [3:0]  dest_index,
    output logic [3:0]  nzcv_out,
    output logic        cond_passed,
    output logic        handled
);

    // queue handshake between front and back
    logic      q_valid;
    logic      q_ready;
    dec_item_t q_item;

    // front: captures the item and picks the shift amount
    dpalu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .instr_word       (instr_word),
        .first_operand    (first_operand),
        .shift_source     (shift_source),
        .shift_amount_reg (shift_amount_reg),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item)
    );

    // back: condition, shifter, alu, flags, output register
    dpalu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .result_write (result_write),
        .dest_index   (dest_index),
        .nzcv_out     (nzcv_out),
        .cond_passed  (cond_passed),
        .handled      (handled)
    );

endmodule

/* design/dpalu_front.sv */
module dpalu_front
    import dpalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr_word,
    input  logic [31:0] first_operand,
    input  logic [31:0] shift_source,
    input  logic [31:0] shift_amount_reg,
    output logic        q_valid,
    input  logic        q_ready,
    output dec_item_t   q_item
);

    // two-entry queue, front side registers the item
    dec_item_t   mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    dec_item_t   item;
    logic        push, pop;

    always_comb
    begin
        item.instr = instr_word;
        item.rn    = first_operand;
        item.rm    = shift_source;
        // shift amount: register bottom byte or immediate field
        item.amt   = instr_word[4] ? shift_amount_reg[7:0] : {3'd0, instr_word[11:7]};
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* design/dpalu_back.sv */
module dpalu_back
    import dpalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  dec_item_t   q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic        result_write,
    output logic [3:0]  dest_index,
    output logic [3:0]  nzcv_out,
    output logic        cond_passed,
    output logic        handled
);

    logic [3:0]  flags_reg;
    logic        out_valid_reg;
    logic [31:0] res_reg;
    logic        wr_reg, pass_reg, hnd_reg;
    logic [3:0]  dest_reg, nzcv_reg;

    logic [31:0] ir, rn, rm, op2, res, rot_src, ror_val;
    logic [7:0]  amt;
    logic        fn, fz, fc, fv, pass, is_clz, hnd, wr, sc, nc, nv, logical, take;
    logic [4:0]  rot;
    logic [5:0]  clz;
    logic [32:0] sum, aa, bb;
    logic        cin, by_reg;
    logic [3:0]  flags_next;
    alu_op_t     opc;
    shift_kind_t kind;

    assign {fn, fz, fc, fv} = flags_reg;
    assign ir  = q_item.instr;
    assign rn  = q_item.rn;
    assign rm  = q_item.rm;
    assign amt = q_item.amt;
    assign opc = alu_op_t'(ir[24:21]);
    assign kind = shift_kind_t'(ir[6:5]);
    assign by_reg = ir[4];
    assign is_clz = (ir & CLZ_MASK) == CLZ_PATTERN;

    always_comb
    begin
        case (ir[31:28])
            4'h0: pass = fz;
            4'h1: pass = !fz;
            4'h2: pass = fc;
            4'h3: pass = !fc;
            4'h4: pass = fn;
            4'h5: pass = !fn;
            4'h6: pass = fv;
            4'h7: pass = !fv;
            4'h8: pass = fc && !fz;
            4'h9: pass = !fc || fz;
            4'hA: pass = fn == fv;
            4'hB: pass = fn != fv;
            4'hC: pass = !fz && (fn == fv);
            4'hD: pass = fz || (fn != fv);
            default: pass = 1'b1;
        endcase
    end

    // operand two: immediate rotate or barrel shift
    always_comb
    begin
        op2 = 32'd0;
        sc  = fc;
        hnd = 1'b0;
        rot = 5'd0;
        rot_src = rm;
        if (ir[27:25] == 3'b001)
        begin
            rot = {ir[11:8], 1'b0};
            rot_src = {24'd0, ir[7:0]};
        end
        else
        begin
            rot = amt[4:0];
        end
        ror_val = (rot_src >> rot) | (rot_src << (6'd32 - {1'b0, rot}));
        if (ir[27:25] == 3'b001)
        begin
            hnd = 1'b1;
            op2 = ror_val;
            sc  = (rot == 5'd0) ? fc : ror_val[31];
        end
        else if (ir[27:25] == 3'b000 && !(ir[7] && ir[4]))
        begin
            hnd = 1'b1;
            if (!by_reg && amt == 8'd0)
            begin
                case (kind)
                    SH_LSL: begin op2 = rm; sc = fc; end
                    SH_LSR: begin op2 = 32'd0; sc = rm[31]; end
                    SH_ASR: begin op2 = {32{rm[31]}}; sc = rm[31]; end
                    default: begin op2 = {fc, rm[31:1]}; sc = rm[0]; end
                endcase
            end
            else if (amt == 8'd0)
            begin
                op2 = rm;
                sc  = fc;
            end
            else
            begin
                case (kind)
                    SH_LSL:
                        if (amt < 8'd32)
                        begin
                            op2 = rm << amt[4:0];
                            sc  = rm[5'd0 - amt[4:0]];
                        end
                        else
                        begin
                            op2 = 32'd0;
                            sc  = (amt == 8'd32) ? rm[0] : 1'b0;
                        end
                    SH_LSR:
                        if (amt < 8'd32)
                        begin
                            op2 = rm >> amt[4:0];
                            sc  = rm[amt[4:0] - 5'd1];
                        end
                        else
                        begin
                            op2 = 32'd0;
                            sc  = (amt == 8'd32) ? rm[31] : 1'b0;
                        end
                    SH_ASR:
                        if (amt < 8'd32)
                        begin
                            op2 = 32'($signed(rm) >>> amt[4:0]);
                            sc  = rm[amt[4:0] - 5'd1];
                        end
                        else
                        begin
                            op2 = {32{rm[31]}};
                            sc  = rm[31];
                        end
                    default:
                        if (amt[4:0] == 5'd0)
                        begin
                            op2 = rm;
                            sc  = rm[31];
                        end
                        else
                        begin
                            op2 = ror_val;
                            sc  = rm[amt[4:0] - 5'd1];
                        end
                endcase
            end
        end
        if (hnd && ir[24:23] == 2'b10 && !ir[20])
        begin
            hnd = is_clz;
        end
    end

    always_comb
    begin
        clz = 6'd32;
        for (int i = 0; i < 32; i++)
        begin
            if (rm[i]) clz = 6'(31 - i);
        end
    end

    // single adder shared by all arithmetic ops
    always_comb
    begin
        aa = {1'b0, rn};
        bb = {1'b0, op2};
        cin = 1'b0;
        case (opc)
            OP_SUB, OP_CMP: begin bb = {1'b0, ~op2}; cin = 1'b1; end
            OP_RSB:         begin aa = {1'b0, op2}; bb = {1'b0, ~rn}; cin = 1'b1; end
            OP_ADC:         cin = fc;
            OP_SBC:         begin bb = {1'b0, ~op2}; cin = fc; end
            OP_RSC:         begin aa = {1'b0, op2}; bb = {1'b0, ~rn}; cin = fc; end
            default:        ;
        endcase
        sum = aa + bb + {32'd0, cin};
    end

    always_comb
    begin
        logical = 1'b1;
        wr = 1'b1;
        case (opc)
            OP_AND, OP_TST: res = rn & op2;
            OP_EOR, OP_TEQ: res = rn ^ op2;
            OP_ORR:         res = rn | op2;
            OP_MOV:         res = op2;
            OP_BIC:         res = rn & ~op2;
            OP_MVN:         res = ~op2;
            default:
            begin
                res = sum[31:0];
                logical = 1'b0;
            end
        endcase
        if (opc inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN}) wr = 1'b0;
        nc = logical ? sc : sum[32];
        nv = logical ? fv : (~(aa[31] ^ bb[31]) & (aa[31] ^ sum[31]));
        flags_next = flags_reg;
        if (!(hnd && pass))
        begin
            wr = 1'b0;
        end
        else if (is_clz)
        begin
            res = {26'd0, clz};
            wr = 1'b1;
        end
        else if (ir[20])
        begin
            flags_next = {res[31], res == 32'd0, nc, nv};
        end
        if (!wr) res = 32'd0;
    end

    assign q_ready = !out_valid_reg || out_ready;
    assign take = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg  <= res;
            wr_reg   <= wr;
            dest_reg <= ir[15:12];
            nzcv_reg <= flags_next;
            pass_reg <= pass;
            hnd_reg  <= hnd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take) flags_reg <= flags_next;
            if (take) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign result_write = wr_reg;
    assign dest_index   = dest_reg;
    assign nzcv_out     = nzcv_reg;
    assign cond_passed  = pass_reg;
    assign handled      = hnd_reg;

endmodule
